// ----- rtl/tdt_pkg.sv -----
package tdt_pkg;

  localparam int SLOTS            = 4;
  localparam int NARROW_TIMERS    = 2;
  localparam int NUM_TIMERS_DEF   = 4;
  localparam int NARROW_BITS_DEF  = 24;
  localparam int DATA_BITS        = 32;
  localparam int CTRL_BITS        = 12;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  localparam logic [3:0] REG_CONTROL = 4'd0;
  localparam logic [3:0] REG_INT     = 4'd1;
  localparam logic [1:0] GRP_RELOAD  = 2'd1;
  localparam logic [1:0] GRP_COUNT   = 2'd2;

  typedef struct packed {
    logic [1:0]           action;
    logic [5:0]           address;
    logic [DATA_BITS-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic [DATA_BITS-1:0] read_data;
    logic                 irq;
  } rsp_t;

  function automatic logic [SLOTS-1:0] present_mask(input int n);
    logic [SLOTS-1:0] m;
    m = '0;
    for (int t = 0; t < SLOTS; t++) begin
      if (t < n) m[t] = 1'b1;
    end
    return m;
  endfunction

  function automatic logic [CTRL_BITS-1:0] control_mask(input int n);
    logic [CTRL_BITS-1:0] m;
    m = '0;
    for (int t = 0; t < SLOTS; t++) begin
      if (t < n) begin
        m[2*t]     = 1'b1;
        m[2*t+1]   = 1'b1;
        m[8+t]     = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

// ----- rtl/tdt_channel.sv -----
module tdt_channel
  import tdt_pkg::*;
#(
  parameter int WIDTH = DATA_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             tick,
  input  logic             periodic,
  input  logic             wr_reload,
  input  logic             wr_count,
  input  logic [WIDTH-1:0] write_data,
  output logic [WIDTH-1:0] reload,
  output logic [WIDTH-1:0] count,
  output logic             expire
);

  logic [WIDTH-1:0] count_next;

  always_comb begin
    count_next = count;
    expire     = 1'b0;
    if (wr_count) begin
      count_next = write_data;
    end else if (tick) begin
      if (count == WIDTH'(1)) begin
        expire     = 1'b1;
        count_next = periodic ? reload : '0;
      end else if (count == '0) begin
        if (periodic) count_next = reload;
      end else begin
        count_next = count - WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reload <= '0;
      count  <= '0;
    end else begin
      if (wr_reload) reload <= write_data;
      count <= count_next;
    end
  end

endmodule

// ----- rtl/four_channel_down_timer.sv -----
// Throughput: one request per cycle unless rsp is stalled; each request passes
// an input register, one pass of update logic over all timers, and a response
// register.
// Reset (synchronous, active high): all timers disabled, counters, reloads,
// interrupt enables and pending bits cleared, both pipeline registers empty.
module four_channel_down_timer
  import tdt_pkg::*;
#(
  parameter int NUM_TIMERS  = NUM_TIMERS_DEF,
  parameter int NARROW_BITS = NARROW_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam logic [SLOTS-1:0]     PRESENT   = present_mask(NUM_TIMERS);
  localparam logic [CTRL_BITS-1:0] CTRL_MASK = control_mask(NUM_TIMERS);

  req_t             held;
  logic             held_valid;
  logic             process;
  logic [3:0]       word;
  logic             is_tick;
  logic             is_read;
  logic             is_write;

  logic [CTRL_BITS-1:0] control_bits;
  logic [CTRL_BITS-1:0] control_bits_next;
  logic [SLOTS-1:0]     int_enable;
  logic [SLOTS-1:0]     int_enable_next;
  logic [SLOTS-1:0]     int_pending;
  logic [SLOTS-1:0]     int_pending_next;

  logic [DATA_BITS-1:0] reload_rd [SLOTS];
  logic [DATA_BITS-1:0] count_rd  [SLOTS];
  logic [SLOTS-1:0]     expire;
  logic [DATA_BITS-1:0] read_data;

  assign process   = held_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = held_valid && !process;

  assign word     = held.address[5:2];
  assign is_tick  = process && (held.action == ACT_TICK);
  assign is_read  = held.action == ACT_READ;
  assign is_write = process && (held.action == ACT_WRITE);

  for (genvar t = 0; t < SLOTS; t++) begin : g_timer
    if (t < NUM_TIMERS) begin : g_on
      localparam int W = (t < NARROW_TIMERS) ? NARROW_BITS : DATA_BITS;
      logic [W-1:0] reload;
      logic [W-1:0] count;

      tdt_channel #(.WIDTH(W)) u_channel (
        .clk        (clk),
        .rst        (rst),
        .tick       (is_tick && control_bits[2*t]),
        .periodic   (control_bits[2*t+1]),
        .wr_reload  (is_write && (word == {GRP_RELOAD, 2'(t)})),
        .wr_count   (is_write && (word == {GRP_COUNT, 2'(t)})),
        .write_data (held.write_data[W-1:0]),
        .reload     (reload),
        .count      (count),
        .expire     (expire[t])
      );

      assign reload_rd[t] = DATA_BITS'(reload);
      assign count_rd[t]  = DATA_BITS'(count);
    end else begin : g_off
      assign reload_rd[t] = '0;
      assign count_rd[t]  = '0;
      assign expire[t]    = 1'b0;
    end
  end

  always_comb begin
    control_bits_next = control_bits;
    int_enable_next   = int_enable;
    int_pending_next  = int_pending;
    if (is_tick) begin
      int_pending_next = int_pending | (expire & PRESENT);
    end else if (is_write) begin
      if (word == REG_CONTROL) begin
        control_bits_next = held.write_data[CTRL_BITS-1:0] & CTRL_MASK;
      end else if (word == REG_INT) begin
        int_enable_next  = held.write_data[3:0] & PRESENT;
        int_pending_next = int_pending & ~held.write_data[7:4] & PRESENT;
      end
    end
  end

  always_comb begin
    read_data = '0;
    if (is_read) begin
      if (word == REG_CONTROL) begin
        read_data = DATA_BITS'(control_bits);
      end else if (word == REG_INT) begin
        read_data = DATA_BITS'({int_pending, int_enable});
      end else if (word[3:2] == GRP_RELOAD) begin
        read_data = reload_rd[word[1:0]];
      end else if (word[3:2] == GRP_COUNT) begin
        read_data = count_rd[word[1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid   <= 1'b0;
      rsp_valid    <= 1'b0;
      control_bits <= '0;
      int_enable   <= '0;
      int_pending  <= '0;
    end else begin
      if (req_valid && !req_stall) begin
        held_valid <= 1'b1;
      end else if (process) begin
        held_valid <= 1'b0;
      end
      if (process) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      control_bits <= control_bits_next;
      int_enable   <= int_enable_next;
      int_pending  <= int_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) held <= req;
    if (process) begin
      rsp.read_data <= read_data;
      rsp.irq       <= |(int_enable_next & int_pending_next);
    end
  end

endmodule
